// ----- src/tblp_pkg.sv -----
// Shared types and constants for the term by log position map.
package tblp_pkg;

  localparam int MAP_DEPTH = 64;
  localparam int IDX_W     = $clog2(MAP_DEPTH);
  localparam int CNT_W     = IDX_W + 1;
  localparam int WORD_W    = 64;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef struct packed {
    word_t pos;
    word_t term;
  } entry_t;

  typedef struct packed {
    logic   en;
    idx_t   addr;
    entry_t data;
  } wr_req_t;

  typedef struct packed {
    logic en;
    idx_t addr;
  } rd_req_t;

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

endpackage

// ----- src/tblp_store.sv -----
// Entry store of the map: one write port and one read port with registered read data.
module tblp_store (
  input  logic             clk,
  input  tblp_pkg::wr_req_t wr,
  input  tblp_pkg::rd_req_t rd,
  output tblp_pkg::entry_t  rd_data
);
  import tblp_pkg::*;

  entry_t mem [MAP_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

// ----- src/term_by_log_position_map.sv -----
// Top level of the term by log position map: control, counters and the lookup scan.
//
//   Channel   Direction  Handshake              Ports
//   request   in         start high, busy low   kind, log_position, new_term,
//                                               current_term, consensus_ready
//   result    out        done strobe, 1 cycle   term_found, matched
//
// A record request is written to the store at the edge that accepts it;
// busy does not rise for it and it gives no result.
// A lookup request reads one entry per cycle from the newest pair towards the
// oldest through the single read port of the store, whose read data are
// registered. A hit ends the scan at the newest pair whose position is not
// above the query; a miss ends it once all stored pairs have been read, or
// without any read on an empty table.
// Reset clears the control state, the pair count and the head pointer; the
// store keeps its contents, as no pair beyond the count is ever read.
// The result strobe lasts one cycle and cannot be held off by the receiver.
module term_by_log_position_map (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                kind,
  input  tblp_pkg::word_t     log_position,
  input  tblp_pkg::word_t     new_term,
  input  tblp_pkg::word_t     current_term,
  input  logic                consensus_ready,
  output logic                done,
  output tblp_pkg::word_t     term_found,
  output logic                matched
);
  import tblp_pkg::*;

  state_t  state;
  cnt_t    entry_count;
  idx_t    oldest_slot;
  cnt_t    issue_left;
  cnt_t    issue_left_m1;
  logic    pend;
  word_t   query_pos;
  word_t   fallback_term;

  wr_req_t wr;
  rd_req_t rd;
  entry_t  rd_data;

  logic    accept;
  logic    hit;
  logic    miss_end;

  tblp_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  assign busy   = (state == ST_SCAN);
  assign accept = start && !busy;

  // A new pair goes to the slot after the newest one. When the table is full
  // the count's low bits are zero, so this lands on the oldest slot, which is
  // exactly the pair to be dropped.
  assign wr.en        = accept && (kind == KIND_RECORD);
  assign wr.addr      = oldest_slot + entry_count[IDX_W-1:0];
  assign wr.data.pos  = log_position;
  assign wr.data.term = new_term;

  // The scan issues one read a cycle, newest pair first, while the compare of
  // the previous read takes place on the registered read data.
  assign issue_left_m1 = issue_left - 1'b1;
  assign rd.en         = busy && (issue_left != '0);
  assign rd.addr       = oldest_slot + issue_left_m1[IDX_W-1:0];

  assign hit      = busy && pend && (rd_data.pos <= query_pos);
  assign miss_end = busy && !pend && (issue_left == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      oldest_slot <= '0;
      issue_left  <= '0;
      pend        <= 1'b0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (kind == KIND_RECORD) begin
              if (entry_count == CNT_W'(MAP_DEPTH)) begin
                oldest_slot <= oldest_slot + 1'b1;
              end else begin
                entry_count <= entry_count + 1'b1;
              end
            end else begin
              issue_left <= entry_count;
              pend       <= 1'b0;
              state      <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          pend <= rd.en;
          if (rd.en) begin
            issue_left <= issue_left_m1;
          end
          if (hit || miss_end) begin
            done  <= 1'b1;
            pend  <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers: the query is captured at acceptance and the result
  // is loaded together with the strobe.
  always_ff @(posedge clk) begin
    if (accept && (kind == KIND_LOOKUP)) begin
      query_pos     <= log_position;
      fallback_term <= consensus_ready ? current_term : '0;
    end
    if (hit) begin
      term_found <= rd_data.term;
      matched    <= 1'b1;
    end else if (miss_end) begin
      term_found <= fallback_term;
      matched    <= 1'b0;
    end
  end

endmodule

// ----- src/tblp_checker.sv -----
// Port-level checker for the term by log position map, with its bind statement.
module tblp_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic kind,
  input logic done
);
  import tblp_pkg::*;

  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (kind == KIND_LOOKUP)) |=> busy)
    else $error("lookup request accepted without the block turning busy");

  a_record_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (kind == KIND_RECORD)) |=> (!done && !busy))
    else $error("record request produced a result or a busy period");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a preceding lookup");

  a_busy_ends_done: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> done)
    else $error("lookup finished without a result strobe");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe lasted more than one cycle");

endmodule

bind term_by_log_position_map tblp_checker u_tblp_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .kind  (kind),
  .done  (done)
);

// ----- test/tb_top.sv -----
// Self-checking testbench for the term by log position map, with scoreboard and request drivers.
`timescale 1ns / 1ps

module tb_top;
  import tblp_pkg::*;

  // Answer that one lookup request is expected to give.
  typedef struct packed {
    word_t term;
    logic  matched;
  } lookup_answer_t;

  // The scoreboard keeps its own copy of the pair table, updates it for every accepted
  // request and queues the answer of each lookup until the block gives its result.
  class term_map_scoreboard;
    word_t            start_pos [MAP_DEPTH];
    word_t            term_of [MAP_DEPTH];
    int               pair_count;
    idx_t             head;
    lookup_answer_t   pending_answers [$];
    int               mismatches;

    function new();
      pair_count = 0;
      head       = '0;
      mismatches = 0;
    endfunction

    function void note_request(logic k, word_t pos, word_t term, word_t cur, logic ready);
      idx_t           slot;
      lookup_answer_t ans;
      logic           hit;
      int             i;
      if (k == KIND_RECORD) begin
        if (pair_count < MAP_DEPTH) begin
          slot = head + idx_t'(pair_count);
          pair_count++;
        end else begin
          // The table is full, so the oldest pair gives way and the head moves on.
          slot = head;
          head = head + 1'b1;
        end
        start_pos[slot] = pos;
        term_of[slot]   = term;
      end else begin
        ans.term    = ready ? cur : '0;
        ans.matched = 1'b0;
        hit         = 1'b0;
        for (i = pair_count - 1; i >= 0 && !hit; i--) begin
          slot = head + idx_t'(i);
          if (start_pos[slot] <= pos) begin
            ans.term    = term_of[slot];
            ans.matched = 1'b1;
            hit         = 1'b1;
          end
        end
        pending_answers.push_back(ans);
      end
    endfunction

    task report_mismatch(string what, word_t got, word_t want);
      $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      mismatches++;
    endtask

    task check_result(word_t got_term, logic got_matched);
      lookup_answer_t want;
      if (pending_answers.size() == 0) begin
        report_mismatch("unrequested result", got_term, '0);
      end else begin
        want = pending_answers.pop_front();
        if (got_matched !== want.matched) begin
          report_mismatch("matched", word_t'(got_matched), word_t'(want.matched));
        end
        if (got_term !== want.term) begin
          report_mismatch("term_found", got_term, want.term);
        end
      end
    endtask

    function int pending();
      return pending_answers.size();
    endfunction
  endclass

  // Longest legal quiet stretch is a long sender gap plus a full scan of the table, so this
  // leaves a wide margin while still catching a hung block quickly.
  localparam int IDLE_LIMIT    = 2000;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int DRAIN_CYCLES  = 80;
  localparam word_t WORD_MAX   = '1;

  logic  clk             = 1'b0;
  logic  rst             = 1'b1;
  logic  start           = 1'b0;
  logic  kind            = KIND_RECORD;
  word_t log_position    = '0;
  word_t new_term        = '0;
  word_t current_term    = '0;
  logic  consensus_ready = 1'b0;
  logic  busy;
  logic  done;
  word_t term_found;
  logic  matched;

  term_map_scoreboard sb = new();

  int    idle_cycles   = 0;
  int    no_idle_left  = 0;
  word_t recent_pos [$];
  word_t next_pos      = 64'd1000;
  word_t next_term     = 64'd1;

  term_by_log_position_map u_top (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .kind            (kind),
    .log_position    (log_position),
    .new_term        (new_term),
    .current_term    (current_term),
    .consensus_ready (consensus_ready),
    .done            (done),
    .term_found      (term_found),
    .matched         (matched)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Results are sampled at the rising edge that closes their strobe cycle; the block
  // updates its outputs with nonblocking assignments, so the values read here are the
  // ones that were presented during that cycle.
  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_result(term_found, matched);
    end
  end

  // The watchdog counts cycles in which neither a request nor a result is accepted.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("[%0t] watchdog: no activity for %0d cycles", $realtime, IDLE_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one, and occasional stretches
  // in which the sender never idles at all.
  function automatic int pick_gap();
    int r;
    if (no_idle_left > 0) begin
      no_idle_left--;
      return 0;
    end
    if ($urandom_range(0, 199) == 0) begin
      no_idle_left = $urandom_range(30, 120);
    end
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Presents one request and holds it until the block takes it. When no gap is wanted,
  // start simply stays high from the previous request, so it is never dropped and raised
  // within the same time step.
  task automatic send_request(input logic k, input word_t pos, input word_t term,
                              input word_t cur, input logic ready);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    kind            <= k;
    log_position    <= pos;
    new_term        <= term;
    current_term    <= cur;
    consensus_ready <= ready;
    start           <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(k, pos, term, cur, ready);
    if (k == KIND_RECORD) begin
      recent_pos.push_back(pos);
      if (recent_pos.size() > MAP_DEPTH) begin
        void'(recent_pos.pop_front());
      end
    end
  endtask

  // Records are mostly well-formed, with start positions and terms that rise, and
  // sometimes arbitrary noise. Lookups aim at or just around recorded positions so that
  // hits land at every depth of the scan, with some misses and extreme positions mixed in.
  task automatic send_random_request();
    int    r;
    word_t pos;
    word_t term;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      if ($urandom_range(0, 4) != 0) begin
        next_pos  = next_pos + word_t'($urandom_range(1, 500));
        if ($urandom_range(0, 19) == 0) begin
          next_pos = next_pos + (rand_word() >> 8);
        end
        next_term = next_term + word_t'($urandom_range(1, 3));
        pos       = next_pos;
        term      = next_term;
      end else begin
        pos  = rand_word();
        term = rand_word();
      end
      send_request(KIND_RECORD, pos, term, rand_word(), 1'($urandom));
    end else begin
      r = $urandom_range(0, 99);
      if (recent_pos.size() != 0 && r < 40) begin
        pos = recent_pos[$urandom_range(0, recent_pos.size() - 1)]
              + word_t'($urandom_range(0, 3));
      end else if (recent_pos.size() != 0 && r < 60) begin
        pos = recent_pos[$urandom_range(0, recent_pos.size() - 1)] - 1'b1;
      end else if (r < 80) begin
        pos = rand_word();
      end else if (r < 90) begin
        pos = '0;
      end else begin
        pos = WORD_MAX;
      end
      send_request(KIND_LOOKUP, pos, rand_word(), rand_word(), 1'($urandom));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Lookups on the empty table fall back to the current term, or to zero when no
    // consensus state exists.
    send_request(KIND_LOOKUP, '0, rand_word(), WORD_MAX, 1'b1);
    send_request(KIND_LOOKUP, WORD_MAX, rand_word(), rand_word(), 1'b0);
    // A single pair: a position just below it misses, the exact position and the top
    // of the range hit it.
    send_request(KIND_RECORD, 64'd100, 64'd5, rand_word(), 1'b1);
    send_request(KIND_LOOKUP, 64'd99, rand_word(), 64'd7, 1'b1);
    send_request(KIND_LOOKUP, 64'd99, rand_word(), 64'd7, 1'b0);
    send_request(KIND_LOOKUP, 64'd100, rand_word(), 64'd7, 1'b1);
    send_request(KIND_LOOKUP, WORD_MAX, rand_word(), 64'd7, 1'b0);
    // Extreme start positions and terms, recorded out of order.
    send_request(KIND_RECORD, '0, WORD_MAX, WORD_MAX, 1'b1);
    send_request(KIND_RECORD, WORD_MAX, '0, '0, 1'b0);
    send_request(KIND_LOOKUP, WORD_MAX, '0, rand_word(), 1'b1);
    send_request(KIND_LOOKUP, WORD_MAX - 1'b1, WORD_MAX, rand_word(), 1'b1);
    send_request(KIND_LOOKUP, '0, '0, rand_word(), 1'b0);
    send_request(KIND_RECORD, 64'd50, 64'd9, rand_word(), 1'b0);
    send_request(KIND_LOOKUP, 64'd60, rand_word(), rand_word(), 1'b1);
    send_request(KIND_LOOKUP, 64'd49, rand_word(), rand_word(), 1'b1);
    send_request(KIND_LOOKUP, 64'd100, rand_word(), rand_word(), 1'b0);

    // The random part fills the table early on, so most of it runs with the table full
    // and the head wrapping round many times.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      send_random_request();
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
